// ===== src/rolling_vwap_unit_macros.svh =====
// Assertion macros for the rolling VWAP unit RTL.
`ifndef ROLLING_VWAP_UNIT_MACROS_SVH
`define ROLLING_VWAP_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Implication in the same cycle.
`define RVWAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvwap assertion failed");

// Implication in the following cycle.
`define RVWAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvwap assertion failed");

`else

`define RVWAP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RVWAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/rvwap_pkg.sv =====
// Shared constants and types for the rolling VWAP unit.
`timescale 1ns / 1ps
`default_nettype none

package rvwap_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = 9;
    localparam int PRICE_W    = 32;
    localparam int VOL_W      = 24;
    localparam int PROD_W     = PRICE_W + VOL_W;
    localparam int PSUM_W     = 64;
    localparam int VSUM_W     = 32;
    localparam int AVG_W      = 32;
    localparam int DIV_STEPS  = AVG_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int ENTRY_W    = PROD_W + VOL_W;

    typedef struct packed {
        logic accept;
        logic mul;
        logic sub;
        logic add;
        logic dinit;
        logic dstep;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic full;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/rvwap_ifs.sv =====
// Channel interfaces of the rolling VWAP unit: config, tick and result.
`timescale 1ns / 1ps
`default_nettype none

interface rvwap_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rvwap_pkg::WIN_W-1:0]   window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

interface rvwap_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          start_series;
    logic [rvwap_pkg::PRICE_W-1:0] price;
    logic [rvwap_pkg::VOL_W-1:0]   volume;

    modport source (output valid, output start_series, output price, output volume,
                    input ready);
    modport sink   (input valid, input start_series, input price, input volume,
                    output ready);
endinterface

interface rvwap_result_if;
    logic                          valid;
    logic                          ready;
    logic [rvwap_pkg::AVG_W-1:0]   avg_price;
    logic [rvwap_pkg::PSUM_W-1:0]  dollar_volume;
    logic                          zero_volume;

    modport source (output valid, output avg_price, output dollar_volume,
                    output zero_volume, input ready);
    modport sink   (input valid, input avg_price, input dollar_volume,
                    input zero_volume, output ready);
endinterface

`default_nettype wire

// ===== src/rvwap_ctrl.sv =====
// Sequencer of the rolling VWAP unit: tick handshake, update steps, divider, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_vwap_unit_macros.svh"

module rvwap_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tick_valid,
    output logic                  tick_ready,
    input  wire logic             result_ready,
    output logic                  result_valid,
    input  wire rvwap_pkg::stat_t stat,
    output rvwap_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SUB   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [rvwap_pkg::STEP_W-1:0] LAST_STEP =
        rvwap_pkg::STEP_W'(rvwap_pkg::DIV_STEPS - 1);

    logic [2:0]                   state_reg, state_next;
    logic [rvwap_pkg::STEP_W-1:0] step_reg, step_next;
    logic                         valid_reg, valid_next;
    logic                         out_free;

    assign tick_ready   = (state_reg == S_IDLE);
    assign result_valid = valid_reg;
    assign out_free     = !valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.dinit  = 1'b1;
                step_next  = '0;
                state_next = stat.full ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                cmd.dstep  = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    `RVWAP_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `RVWAP_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load, !valid_reg || result_ready)
    `RVWAP_ASSERT_NEXT(a_accept_mul, clk, rst_n, cmd.accept, state_reg == S_MUL)
    `RVWAP_ASSERT_NEXT(a_div_done, clk, rst_n, cmd.dstep && step_reg == LAST_STEP,
                       state_reg == S_DONE)

endmodule

`default_nettype wire

// ===== src/rvwap_dp.sv =====
// Datapath of the rolling VWAP unit: window register, ring memory, sums, divider, result.
`timescale 1ns / 1ps
`default_nettype none

module rvwap_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [rvwap_pkg::WIN_W-1:0]     cfg_window_len,
    input  wire logic                            start_series,
    input  wire logic [rvwap_pkg::PRICE_W-1:0]   price,
    input  wire logic [rvwap_pkg::VOL_W-1:0]     volume,
    input  wire rvwap_pkg::cmd_t                 cmd,
    output rvwap_pkg::stat_t                     stat,
    output logic [rvwap_pkg::AVG_W-1:0]          avg_price,
    output logic [rvwap_pkg::PSUM_W-1:0]         dollar_volume,
    output logic                                 zero_volume
);

    localparam logic [rvwap_pkg::WIN_W-1:0] WIN_MAX = rvwap_pkg::WIN_W'(rvwap_pkg::MAX_WINDOW);
    localparam logic [rvwap_pkg::WIN_W-1:0] WIN_ONE = rvwap_pkg::WIN_W'(1);

    logic [rvwap_pkg::WIN_W-1:0]   win_reg;
    logic [rvwap_pkg::WIN_W-1:0]   win_eff;
    logic [rvwap_pkg::WIN_W-1:0]   fill_reg;
    logic [rvwap_pkg::SLOT_W-1:0]  slot_reg;
    logic                          evict_reg;
    logic [rvwap_pkg::PSUM_W-1:0]  psum_reg;
    logic [rvwap_pkg::VSUM_W-1:0]  vsum_reg;

    logic [rvwap_pkg::PRICE_W-1:0] price_reg;
    logic [rvwap_pkg::VOL_W-1:0]   vol_reg;
    logic [rvwap_pkg::PROD_W-1:0]  prod_reg;
    logic [rvwap_pkg::ENTRY_W-1:0] rd_reg;
    logic [rvwap_pkg::ENTRY_W-1:0] ring [rvwap_pkg::MAX_WINDOW];
    logic [rvwap_pkg::SLOT_W-1:0]  rd_addr;

    logic [rvwap_pkg::VSUM_W-1:0]  rem_reg;
    logic [rvwap_pkg::AVG_W-1:0]   quo_reg;
    logic [rvwap_pkg::VSUM_W+1:0]  diff;
    logic                          fits;

    logic [rvwap_pkg::AVG_W-1:0]   avg_reg;
    logic [rvwap_pkg::PSUM_W-1:0]  dv_reg;
    logic                          zero_reg;

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = WIN_ONE;
        end
        else if (win_reg > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
        else
        begin
            win_eff = win_reg;
        end
    end

    assign rd_addr   = slot_reg - win_eff[rvwap_pkg::SLOT_W-1:0];
    assign stat.full = (fill_reg >= win_eff);

    // restoring divide step: shift in next dividend bit, subtract if it fits
    assign diff = {1'b0, rem_reg, quo_reg[rvwap_pkg::AVG_W-1]} - {2'b00, vsum_reg};
    assign fits = !diff[rvwap_pkg::VSUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= WIN_ONE;
            fill_reg  <= '0;
            slot_reg  <= '0;
            evict_reg <= 1'b0;
            psum_reg  <= '0;
            vsum_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                win_reg <= cfg_window_len;
            end
            if (cmd.accept && start_series)
            begin
                psum_reg <= '0;
                vsum_reg <= '0;
                fill_reg <= '0;
            end
            if (cmd.mul)
            begin
                fill_reg  <= (fill_reg > win_eff) ? win_eff : fill_reg;
                evict_reg <= (fill_reg >= win_eff);
            end
            if (cmd.sub && evict_reg)
            begin
                psum_reg <= psum_reg
                          - rvwap_pkg::PSUM_W'(rd_reg[rvwap_pkg::ENTRY_W-1:rvwap_pkg::VOL_W]);
                vsum_reg <= vsum_reg - rvwap_pkg::VSUM_W'(rd_reg[rvwap_pkg::VOL_W-1:0]);
            end
            if (cmd.add)
            begin
                psum_reg <= psum_reg + rvwap_pkg::PSUM_W'(prod_reg);
                vsum_reg <= vsum_reg + rvwap_pkg::VSUM_W'(vol_reg);
                slot_reg <= slot_reg + 1'b1;
                if (fill_reg < win_eff)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            price_reg <= price;
            vol_reg   <= volume;
        end
        if (cmd.mul)
        begin
            prod_reg <= rvwap_pkg::PROD_W'(price_reg * vol_reg);
            rd_reg   <= ring[rd_addr];
        end
        if (cmd.add)
        begin
            ring[slot_reg] <= {prod_reg, vol_reg};
        end
        if (cmd.dinit)
        begin
            rem_reg <= psum_reg[rvwap_pkg::PSUM_W-1:rvwap_pkg::AVG_W];
            quo_reg <= psum_reg[rvwap_pkg::AVG_W-1:0];
        end
        if (cmd.dstep)
        begin
            rem_reg <= fits ? diff[rvwap_pkg::VSUM_W-1:0]
                            : {rem_reg[rvwap_pkg::VSUM_W-2:0], quo_reg[rvwap_pkg::AVG_W-1]};
            quo_reg <= {quo_reg[rvwap_pkg::AVG_W-2:0], fits};
        end
        if (cmd.load)
        begin
            avg_reg  <= (vsum_reg == '0) ? '0 : quo_reg;
            dv_reg   <= psum_reg;
            zero_reg <= (vsum_reg == '0);
        end
    end

    assign avg_price     = avg_reg;
    assign dollar_volume = dv_reg;
    assign zero_volume   = zero_reg;

endmodule

`default_nettype wire

// ===== src/rolling_vwap_unit.sv =====
// Top level of the rolling VWAP unit.
//
//   channel  dir   beat payload
//   cfg      in    window_len
//   tick     in    start_series, price, volume
//   result   out   avg_price, dollar_volume, zero_volume
//
// A tick runs multiply, subtract, add and divider setup; a full window adds the 32-step
// restoring divider and result load. The ring sits in one memory with one write and
// one registered read a cycle. Reset clears sums, slot and fill count; the ring holds
// no reset value and needs no clearing pass. A stalled result beat holds in the output
// register while the next tick is taken in; only its final load waits for the sink.
`timescale 1ns / 1ps
`default_nettype none

module rolling_vwap_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rvwap_cfg_if.sink      cfg,
    rvwap_tick_if.sink     tick,
    rvwap_result_if.source result
);

    rvwap_pkg::cmd_t  cmd;
    rvwap_pkg::stat_t stat;

    assign cfg.ready = 1'b1;

    rvwap_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick.valid),
        .tick_ready   (tick.ready),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .stat         (stat),
        .cmd          (cmd)
    );

    rvwap_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg.valid),
        .cfg_window_len (cfg.window_len),
        .start_series   (tick.start_series),
        .price          (tick.price),
        .volume         (tick.volume),
        .cmd            (cmd),
        .stat           (stat),
        .avg_price      (result.avg_price),
        .dollar_volume  (result.dollar_volume),
        .zero_volume    (result.zero_volume)
    );

endmodule

`default_nettype wire
